// ===== design/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the priority ready queue
// Command and status codes, payload structs, list entry and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam int PRQ_MAX_TASKS = 16;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_SEL = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_DUP     = 2'd3;

    localparam logic CFG_IDLE_TASK_ID  = 1'b0;
    localparam logic CFG_IDLE_PRIORITY = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] task_id;
        logic [7:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [7:0] chosen_task;
        logic       chose_idle;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] prio;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic step;
        logic first;
    } t_cmp_ctl;

    typedef struct packed {
        logic       found;
        logic [7:0] best_task;
        logic [7:0] best_prio;
    } t_cmp_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/prq_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// prq_cmp_unit: shared compare unit of the list scan
// Takes one list entry per step; tracks the first id match and the earliest
// entry of highest priority.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_cmp_unit
    import prq_pkg::*;
#(
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmp_ctl      i_ctl,
    input  wire logic [AW-1:0] i_index,
    input  wire logic [7:0]    i_key,
    input  wire t_entry        i_entry,
    output t_cmp_res           o_res,
    output logic [AW-1:0]      o_slot
);

    logic          r_found;
    logic [AW-1:0] r_slot;
    logic [7:0]    r_best_task;
    logic [7:0]    r_best_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.step && !r_found && (i_entry.task_id == i_key)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && !r_found && (i_entry.task_id == i_key)) begin
            r_slot <= i_index;
        end
        if (i_ctl.step && (i_ctl.first || (i_entry.prio > r_best_prio))) begin
            r_best_task <= i_entry.task_id;
            r_best_prio <= i_entry.prio;
        end
    end

    always_comb begin
        o_res.found     = r_found;
        o_res.best_task = r_best_task;
        o_res.best_prio = r_best_prio;
        o_slot          = r_slot;
    end

endmodule

`default_nettype wire

// ===== design/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue: ready list of tasks with priority selection
// Sequencer over a list memory and one shared compare unit.
// ----------------------------------------------------------------------------
// The block takes one command at a time. Every command first scans the list
// one entry per cycle through a single read port of the list memory, then
// acts in ST_EXEC, and ST_DONE loads the answer into the output register once
// that register is free: select answers this way, enqueue likewise with one
// memory write. Dequeue then closes the gap behind the removed entry in
// ST_SHIFT, one entry a cycle since reads and writes share the memory. With an
// empty list the scan is skipped. A new beat is taken the cycle after the
// answer is loaded. The result waits in an output register; a new command is
// taken while it waits. No clearing pass follows reset: the list is empty at
// once.
`default_nettype none

module priority_ready_queue
    import prq_pkg::*;
#(
    parameter int MAX_TASKS = PRQ_MAX_TASKS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_state        r_state, n_state;
    t_in           r_req, n_req;
    t_out          r_res, n_res;
    t_out          r_out;
    logic          r_out_valid;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_didx, n_didx;
    logic          r_pend, n_pend;
    logic [7:0]    r_idle_task_id;
    logic [7:0]    r_idle_priority;

    t_entry        r_mem [MAX_TASKS];
    t_entry        r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;

    t_cmp_ctl      cmp_ctl;
    t_cmp_res      cmp_res;
    logic [AW-1:0] cmp_slot;
    logic          out_load;

    prq_cmp_unit #(
        .AW (AW)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_index (r_didx),
        .i_key   (r_req.task_id),
        .i_entry (r_rdata),
        .o_res   (cmp_res),
        .o_slot  (cmp_slot)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_task_id  <= 8'd0;
            r_idle_priority <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDLE_TASK_ID:  r_idle_task_id  <= i_cfg_wdata;
                CFG_IDLE_PRIORITY: r_idle_priority <= i_cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_idx  <= n_idx;
        r_didx <= n_didx;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_count   = r_count;
        n_idx     = r_idx;
        n_didx    = r_didx;
        n_pend    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_didx;
        mem_wdata = r_rdata;
        mem_raddr = r_idx[AW-1:0];
        cmp_ctl   = '0;
        out_load  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req         = i_in;
                    n_idx         = '0;
                    cmp_ctl.clear = 1'b1;
                    n_state       = (r_count == '0) ? ST_EXEC : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx != r_count) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_didx = r_idx[AW-1:0];
                end
                if (r_pend) begin
                    cmp_ctl.step  = 1'b1;
                    cmp_ctl.first = (r_didx == '0);
                end
                if ((r_idx == r_count) && r_pend) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res.chosen_task = r_req.task_id;
                n_res.chose_idle  = 1'b0;
                n_res.status      = STAT_OK;
                n_state           = ST_DONE;
                unique case (r_req.command)
                    CMD_ENQ: begin
                        if (cmp_res.found) begin
                            n_res.status = STAT_DUP;
                        end else if (r_count == CW'(MAX_TASKS)) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            mem_we            = 1'b1;
                            mem_waddr         = r_count[AW-1:0];
                            mem_wdata.task_id = r_req.task_id;
                            mem_wdata.prio    = r_req.priority_req;
                            n_count           = r_count + CW'(1);
                        end
                    end
                    CMD_DEQ: begin
                        if (!cmp_res.found) begin
                            n_res.status = STAT_MISSING;
                        end else begin
                            n_idx   = CW'(cmp_slot) + CW'(1);
                            n_state = ST_SHIFT;
                        end
                    end
                    CMD_SEL: begin
                        if ((r_count == '0) || (r_idle_priority > cmp_res.best_prio)) begin
                            n_res.chosen_task = r_idle_task_id;
                            n_res.chose_idle  = 1'b1;
                        end else begin
                            n_res.chosen_task = cmp_res.best_task;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SHIFT: begin
                if (r_idx != r_count) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_didx = AW'(r_idx - CW'(1));
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if ((r_idx == r_count) && !r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
